@@ hw/rtl/mm3_pkg.sv @@
`default_nettype none

package mm3_pkg;

   localparam int DATA_W    = 32;
   localparam int MODE_W    = 2;
   localparam int DIM       = 3;
   localparam int NUM_ELEMS = DIM * DIM;

   localparam logic [MODE_W-1:0] MODE_MUL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUB  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

   typedef logic [DATA_W-1:0]         elem_type;
   typedef elem_type [DIM-1:0]        row_type;
   typedef elem_type [NUM_ELEMS-1:0]  mat_type;

   typedef struct packed {
      logic                load;
      logic [MODE_W-1:0]   mode;
   } lane_ctl_type;

   typedef struct packed {
      logic cof_en;
      logic term_en;
   } det_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/mm3_if.sv @@
`default_nettype none

interface mm3_req_if;
   import mm3_pkg::*;

   logic                       valid;
   logic                       ready;
   logic        [MODE_W-1:0]   mode;
   logic signed [DATA_W-1:0]   b_r0c0;
   logic signed [DATA_W-1:0]   b_r0c1;
   logic signed [DATA_W-1:0]   b_r0c2;
   logic signed [DATA_W-1:0]   b_r1c0;
   logic signed [DATA_W-1:0]   b_r1c1;
   logic signed [DATA_W-1:0]   b_r1c2;
   logic signed [DATA_W-1:0]   b_r2c0;
   logic signed [DATA_W-1:0]   b_r2c1;
   logic signed [DATA_W-1:0]   b_r2c2;

   modport source (
      output valid, mode, b_r0c0, b_r0c1, b_r0c2, b_r1c0, b_r1c1, b_r1c2,
             b_r2c0, b_r2c1, b_r2c2,
      input  ready
   );

   modport sink (
      input  valid, mode, b_r0c0, b_r0c1, b_r0c2, b_r1c0, b_r1c1, b_r1c2,
             b_r2c0, b_r2c1, b_r2c2,
      output ready
   );
endinterface

interface mm3_rsp_if;
   import mm3_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   a_r0c0;
   logic signed [DATA_W-1:0]   a_r0c1;
   logic signed [DATA_W-1:0]   a_r0c2;
   logic signed [DATA_W-1:0]   a_r1c0;
   logic signed [DATA_W-1:0]   a_r1c1;
   logic signed [DATA_W-1:0]   a_r1c2;
   logic signed [DATA_W-1:0]   a_r2c0;
   logic signed [DATA_W-1:0]   a_r2c1;
   logic signed [DATA_W-1:0]   a_r2c2;
   logic signed [DATA_W-1:0]   determinant;

   modport source (
      output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
             a_r2c0, a_r2c1, a_r2c2, determinant,
      input  ready
   );

   modport sink (
      input  valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
             a_r2c0, a_r2c1, a_r2c2, determinant,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/mm3_lane.sv @@
`default_nettype none

// One accumulator element: three registered partial terms, summed on read.
module mm3_lane (
   input  wire                    clock,
   input  wire mm3_pkg::lane_ctl_type ctl,
   input  wire mm3_pkg::row_type  a_row,
   input  wire mm3_pkg::row_type  b_col,
   input  wire mm3_pkg::elem_type a_self,
   input  wire mm3_pkg::elem_type b_self,
   output mm3_pkg::elem_type      sum
);
   import mm3_pkg::*;

   row_type p_ff;
   row_type p_in;

   always_comb begin
      p_in = p_ff;
      if (ctl.load) begin
         case (ctl.mode)
            MODE_MUL: begin
               for (int k = 0; k < DIM; k++) begin
                  p_in[k] = a_row[k] * b_col[k];
               end
            end
            MODE_ADD: begin
               p_in[0] = a_self;
               p_in[1] = b_self;
               p_in[2] = '0;
            end
            MODE_SUB: begin
               p_in[0] = a_self;
               p_in[1] = elem_type'(0) - b_self;
               p_in[2] = '0;
            end
            default: begin
               p_in[0] = a_self;
               p_in[1] = '0;
               p_in[2] = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign sum = p_ff[0] + p_ff[1] + p_ff[2];

endmodule

`default_nettype wire

@@ hw/rtl/mm3_det.sv @@
`default_nettype none

// Determinant by first-row cofactor expansion, two registered multiply steps.
module mm3_det (
   input  wire                    clock,
   input  wire mm3_pkg::det_ctl_type ctl,
   input  wire mm3_pkg::mat_type  m,
   output mm3_pkg::elem_type      det
);
   import mm3_pkg::*;

   elem_type [5:0] cp_ff;
   elem_type [5:0] cp_in;
   row_type        t_ff;
   row_type        t_in;

   always_comb begin
      cp_in = cp_ff;
      if (ctl.cof_en) begin
         cp_in[0] = m[4] * m[8];
         cp_in[1] = m[5] * m[7];
         cp_in[2] = m[3] * m[8];
         cp_in[3] = m[5] * m[6];
         cp_in[4] = m[3] * m[7];
         cp_in[5] = m[4] * m[6];
      end
   end

   always_comb begin
      t_in = t_ff;
      if (ctl.term_en) begin
         t_in[0] = m[0] * (cp_ff[0] - cp_ff[1]);
         t_in[1] = m[1] * (cp_ff[2] - cp_ff[3]);
         t_in[2] = m[2] * (cp_ff[4] - cp_ff[5]);
      end
   end

   always_ff @(posedge clock) begin
      cp_ff <= cp_in;
      t_ff  <= t_in;
   end

   assign det = t_ff[0] - t_ff[1] + t_ff[2];

endmodule

`default_nettype wire

@@ hw/rtl/matrix3x3_accumulator_alu.sv @@
// 3x3 accumulator ALU on 32-bit wrapping integers. Each request transaction carries
// a mode (multiply, add, subtract, hold) and an operand matrix; each one returns the
// accumulator after the step and its determinant. Nine lanes, one per element, form
// their partial terms from the accumulator and the operand in the accept cycle;
// the accumulator is rewritten in the following cycle, and the determinant unit needs two
// more multiply steps before the result is loaded into the output register. A new
// item is accepted only while idle or as a result is loaded, so an item is not taken
// before the last one is through; this is set by the accumulator feedback through the
// lanes and the determinant chain. The response register frees the input side while a
// result waits. The accumulator is zero after reset.
`default_nettype none

module matrix3x3_accumulator_alu (
   input  wire      clock,
   input  wire      reset,
   mm3_req_if.sink  req_chan,
   mm3_rsp_if.source rsp_chan
);
   import mm3_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_COF  = 3'd2;
   localparam logic [2:0] ST_TERM = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]   state_ff;
   logic [2:0]   state_in;
   mat_type      acc_ff;
   mat_type      acc_in;
   mat_type      rsp_acc_ff;
   elem_type     rsp_det_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   mat_type      b_mat;
   mat_type      lane_sum;
   elem_type     det;
   logic         out_free;
   logic         out_load;
   logic         accept;
   lane_ctl_type lane_ctl;
   det_ctl_type  det_ctl;

   assign b_mat[0] = elem_type'(req_chan.b_r0c0);
   assign b_mat[1] = elem_type'(req_chan.b_r0c1);
   assign b_mat[2] = elem_type'(req_chan.b_r0c2);
   assign b_mat[3] = elem_type'(req_chan.b_r1c0);
   assign b_mat[4] = elem_type'(req_chan.b_r1c1);
   assign b_mat[5] = elem_type'(req_chan.b_r1c2);
   assign b_mat[6] = elem_type'(req_chan.b_r2c0);
   assign b_mat[7] = elem_type'(req_chan.b_r2c1);
   assign b_mat[8] = elem_type'(req_chan.b_r2c2);

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign out_load       = (state_ff == ST_OUT) && out_free;
   assign req_chan.ready = (state_ff == ST_IDLE) || out_load;
   assign accept         = req_chan.valid && req_chan.ready;

   assign lane_ctl.load = accept;
   assign lane_ctl.mode = req_chan.mode;

   assign det_ctl.cof_en  = (state_ff == ST_COF);
   assign det_ctl.term_en = (state_ff == ST_TERM);

   for (genvar r = 0; r < DIM; r++) begin : g_row
      for (genvar c = 0; c < DIM; c++) begin : g_col
         row_type a_row;
         row_type b_col;

         for (genvar k = 0; k < DIM; k++) begin : g_k
            assign a_row[k] = acc_ff[r*DIM + k];
            assign b_col[k] = b_mat[k*DIM + c];
         end

         mm3_lane u_lane (
            .clock  (clock),
            .ctl    (lane_ctl),
            .a_row  (a_row),
            .b_col  (b_col),
            .a_self (acc_ff[r*DIM + c]),
            .b_self (b_mat[r*DIM + c]),
            .sum    (lane_sum[r*DIM + c])
         );
      end
   end

   mm3_det u_det (
      .clock (clock),
      .ctl   (det_ctl),
      .m     (acc_ff),
      .det   (det)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SUM;
         ST_SUM:  state_in = ST_COF;
         ST_COF:  state_in = ST_TERM;
         ST_TERM: state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) state_in = accept ? ST_SUM : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // merge the lanes back into the accumulator
   assign acc_in = (state_ff == ST_SUM) ? lane_sum : acc_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_acc_ff <= acc_ff;
         rsp_det_ff <= det;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.a_r0c0      = signed'(rsp_acc_ff[0]);
   assign rsp_chan.a_r0c1      = signed'(rsp_acc_ff[1]);
   assign rsp_chan.a_r0c2      = signed'(rsp_acc_ff[2]);
   assign rsp_chan.a_r1c0      = signed'(rsp_acc_ff[3]);
   assign rsp_chan.a_r1c1      = signed'(rsp_acc_ff[4]);
   assign rsp_chan.a_r1c2      = signed'(rsp_acc_ff[5]);
   assign rsp_chan.a_r2c0      = signed'(rsp_acc_ff[6]);
   assign rsp_chan.a_r2c1      = signed'(rsp_acc_ff[7]);
   assign rsp_chan.a_r2c2      = signed'(rsp_acc_ff[8]);
   assign rsp_chan.determinant = signed'(rsp_det_ff);

   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SUM))
      else $error("accepted transaction did not advance to the lane sum");

   a_sum_to_cof: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |=> (state_ff == ST_COF))
      else $error("lane sum did not advance to the cofactor step");

   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SUM) |=> $stable(acc_ff))
      else $error("accumulator changed outside the lane sum");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("response raised without a finished determinant");

endmodule

`default_nettype wire

@@ verif/matrix3x3_accumulator_alu_checker.sv @@
`timescale 1ns / 1ps

module matrix3x3_accumulator_alu_checker (
   input  logic clock,
   input  logic reset,
   mm3_req_if   req_mon,
   mm3_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending
);
   import mm3_pkg::*;

   typedef struct packed {
      mat_type  acc;
      elem_type det;
   } step_result_type;

   mat_type         acc_model;
   step_result_type expected_q[$];
   int              error_total = 0;

   string field_name [NUM_ELEMS+1] = '{
      "a_r0c0", "a_r0c1", "a_r0c2", "a_r1c0", "a_r1c1", "a_r1c2",
      "a_r2c0", "a_r2c1", "a_r2c2", "determinant"
   };

   function automatic mat_type next_accumulator(input logic [MODE_W-1:0] mode,
                                                input mat_type acc,
                                                input mat_type b);
      mat_type  nxt;
      elem_type sum;
      nxt = acc;
      case (mode)
         MODE_MUL: begin
            // every element comes from the accumulator before the step
            for (int r = 0; r < DIM; r++) begin
               for (int c = 0; c < DIM; c++) begin
                  sum = '0;
                  for (int k = 0; k < DIM; k++)
                     sum = sum + acc[r*DIM+k] * b[k*DIM+c];
                  nxt[r*DIM+c] = sum;
               end
            end
         end
         MODE_ADD: begin
            for (int i = 0; i < NUM_ELEMS; i++) nxt[i] = acc[i] + b[i];
         end
         MODE_SUB: begin
            for (int i = 0; i < NUM_ELEMS; i++) nxt[i] = acc[i] - b[i];
         end
         default: nxt = acc;
      endcase
      return nxt;
   endfunction

   function automatic elem_type determinant_of(input mat_type m);
      elem_type t0;
      elem_type t1;
      elem_type t2;
      t0 = m[0] * (m[4] * m[8] - m[5] * m[7]);
      t1 = m[1] * (m[3] * m[8] - m[5] * m[6]);
      t2 = m[2] * (m[3] * m[7] - m[4] * m[6]);
      return t0 - t1 + t2;
   endfunction

   always @(posedge clock) begin : watch
      step_result_type exp_item;
      step_result_type new_item;
      mat_type         operand;
      mat_type         got;
      if (reset) begin
         acc_model = '0;
         expected_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            operand[0] = req_mon.b_r0c0;
            operand[1] = req_mon.b_r0c1;
            operand[2] = req_mon.b_r0c2;
            operand[3] = req_mon.b_r1c0;
            operand[4] = req_mon.b_r1c1;
            operand[5] = req_mon.b_r1c2;
            operand[6] = req_mon.b_r2c0;
            operand[7] = req_mon.b_r2c1;
            operand[8] = req_mon.b_r2c2;
            acc_model    = next_accumulator(req_mon.mode, acc_model, operand);
            new_item.acc = acc_model;
            new_item.det = determinant_of(acc_model);
            expected_q.push_back(new_item);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got[0] = rsp_mon.a_r0c0;
            got[1] = rsp_mon.a_r0c1;
            got[2] = rsp_mon.a_r0c2;
            got[3] = rsp_mon.a_r1c0;
            got[4] = rsp_mon.a_r1c1;
            got[5] = rsp_mon.a_r1c2;
            got[6] = rsp_mon.a_r2c0;
            got[7] = rsp_mon.a_r2c1;
            got[8] = rsp_mon.a_r2c2;
            if (expected_q.size() == 0) begin
               $error("response transaction with no expected result waiting");
               error_total++;
            end else begin
               exp_item = expected_q.pop_front();
               for (int i = 0; i < NUM_ELEMS; i++) begin
                  if (got[i] !== exp_item.acc[i]) begin
                     $error("%s: expected %0d, actual %0d", field_name[i],
                            $signed(exp_item.acc[i]), $signed(got[i]));
                     error_total++;
                  end
               end
               if (rsp_mon.determinant !== exp_item.det) begin
                  $error("%s: expected %0d, actual %0d", field_name[NUM_ELEMS],
                         $signed(exp_item.det), $signed(rsp_mon.determinant));
                  error_total++;
               end
            end
         end
      end
      mismatches <= error_total;
      pending    <= expected_q.size();
   end

endmodule

@@ verif/matrix3x3_accumulator_alu_test.sv @@
`timescale 1ns / 1ps

module matrix3x3_accumulator_alu_test;
   import mm3_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 300;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   pending;
   int   sent_count  = 0;
   int   taken_count = 0;

   mm3_req_if req_chan ();
   mm3_rsp_if rsp_chan ();

   matrix3x3_accumulator_alu dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   matrix3x3_accumulator_alu_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mat_type fill_matrix(input elem_type v);
      mat_type m;
      for (int i = 0; i < NUM_ELEMS; i++) m[i] = v;
      return m;
   endfunction

   function automatic mat_type diag_matrix(input elem_type v);
      mat_type m;
      m = '0;
      for (int i = 0; i < DIM; i++) m[i*DIM+i] = v;
      return m;
   endfunction

   function automatic elem_type pick_elem();
      elem_type v;
      case ($urandom_range(0, 3))
         0, 1: v = $urandom();
         2:    v = $urandom_range(0, 16) - 8;
         default: begin
            case ($urandom_range(0, 4))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'h0000_0000;
               3:       v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0001;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic mat_type pick_operand();
      mat_type m;
      case ($urandom_range(0, 9))
         0: m = '0;
         1: m = diag_matrix(pick_elem());
         2: m = fill_matrix(pick_elem());
         default: for (int i = 0; i < NUM_ELEMS; i++) m[i] = pick_elem();
      endcase
      return m;
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      logic [MODE_W-1:0] m;
      case ($urandom_range(0, 3))
         0:       m = MODE_MUL;
         1:       m = MODE_ADD;
         2:       m = MODE_SUB;
         default: m = MODE_HOLD;
      endcase
      return m;
   endfunction

   task automatic send_item(input logic [MODE_W-1:0] m, input mat_type b);
      int gap;
      // run back to back in every fourth stretch of items
      gap = ((sent_count / 150) % 4 == 3) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.mode   <= m;
      req_chan.b_r0c0 <= b[0];
      req_chan.b_r0c1 <= b[1];
      req_chan.b_r0c2 <= b[2];
      req_chan.b_r1c0 <= b[3];
      req_chan.b_r1c1 <= b[4];
      req_chan.b_r1c2 <= b[5];
      req_chan.b_r2c0 <= b[6];
      req_chan.b_r2c1 <= b[7];
      req_chan.b_r2c2 <= b[8];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // response side: random stalls, one long hold-off to back up the block
   initial begin : receiver
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ((taken_count / 170) % 4 == 2) ? 0 : $urandom_range(0, 17);
         if (taken_count == 500) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         taken_count++;
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("matrix3x3_accumulator_alu: mismatch");
      $finish;
   end

   initial begin : stimulus
      mat_type seq_mat;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.mode   <= MODE_HOLD;
      req_chan.b_r0c0 <= '0;
      req_chan.b_r0c1 <= '0;
      req_chan.b_r0c2 <= '0;
      req_chan.b_r1c0 <= '0;
      req_chan.b_r1c1 <= '0;
      req_chan.b_r1c2 <= '0;
      req_chan.b_r2c0 <= '0;
      req_chan.b_r2c1 <= '0;
      req_chan.b_r2c2 <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hold right after reset: zero accumulator, operand ignored
      send_item(MODE_HOLD, pick_operand());
      send_item(MODE_ADD, diag_matrix(32'd1));
      send_item(MODE_MUL, fill_matrix(32'h7FFF_FFFF));
      send_item(MODE_ADD, fill_matrix(32'h7FFF_FFFF));
      send_item(MODE_SUB, fill_matrix(32'h8000_0000));
      send_item(MODE_MUL, fill_matrix(32'h8000_0000));
      send_item(MODE_SUB, fill_matrix(32'hFFFF_FFFF));
      send_item(MODE_HOLD, fill_matrix(32'h7FFF_FFFF));
      send_item(MODE_MUL, diag_matrix(32'd1));
      send_item(MODE_MUL, '0);
      seq_mat = '0;
      for (int i = 0; i < NUM_ELEMS; i++) seq_mat[i] = i + 1;
      seq_mat[8] = 32'd10;
      send_item(MODE_ADD, seq_mat);
      // product must use only the old accumulator values
      send_item(MODE_MUL, seq_mat);
      send_item(MODE_SUB, fill_matrix(32'h8000_0000));
      send_item(MODE_ADD, fill_matrix(32'hFFFF_FFFF));
      send_item(MODE_MUL, diag_matrix(32'hFFFF_FFFF));
      send_item(MODE_ADD, diag_matrix(32'h7FFF_FFFF));
      send_item(MODE_MUL, diag_matrix(32'h8000_0000));
      send_item(MODE_SUB, '0);
      send_item(MODE_ADD, seq_mat);
      send_item(MODE_HOLD, fill_matrix(32'h8000_0000));
      send_item(MODE_MUL, pick_operand());
      send_item(MODE_SUB, pick_operand());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 1000) begin
            // drain: wait until every expected result has come back
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_item(pick_mode(), pick_operand());
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("matrix3x3_accumulator_alu: match");
      else
         $display("matrix3x3_accumulator_alu: mismatch");
      $finish;
   end

endmodule
